/* hdl/scfr_pkg.sv */
// Shared types and constants for the sum-checked frame read transaction unit.
// No dependencies; used by scfr_front, scfr_queue, scfr_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

  // Input function codes, carried on the slave-side tuser.
  localparam logic [2:0] FUNC_OPEN  = 3'd0;
  localparam logic [2:0] FUNC_CLOSE = 3'd1;
  localparam logic [2:0] FUNC_READ  = 3'd2;
  localparam logic [2:0] FUNC_BYTE  = 3'd3;
  localparam logic [2:0] FUNC_TICK  = 3'd4;

  localparam logic [7:0] TYPE_BYTE_LONG  = 8'hAA;
  localparam logic [7:0] TYPE_BYTE_SHORT = 8'h55;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // The read request goes out as five bytes.
  localparam logic [2:0] REQ_LAST = 3'd4;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_CLOSED  = 2'd0,
    MODE_READY   = 2'd1,
    MODE_READING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    TYPE_NONE  = 2'd0,
    TYPE_LONG  = 2'd1,
    TYPE_SHORT = 2'd2
  } frame_type_t;

  // One queued command from the front end to the back end.
  typedef struct packed {
    kind_t kind;
    logic  frame_type;
    logic  exact;
  } cmd_t;

  function automatic logic [7:0] request_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h38;
      3'd1:    b = 8'h02;
      3'd2:    b = 8'h00;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hdl/scfr_front.sv */
// Front end: accepts input requests, runs the mode and frame state, and queues
// one command for every request that produces results. Depends on scfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scfr_front #(
  parameter int LONG_ITEMS  = 24,
  parameter int SHORT_ITEMS = 16
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             cfg_we,
  input  wire      [15:0] cfg_wdata,
  input  wire             in_valid,
  input  wire      [2:0]  in_func,
  input  wire      [7:0]  in_rx,
  input  wire             q_full,
  output logic            in_ready,
  output logic            push,
  output scfr_pkg::cmd_t  push_cmd
);

  scfr_pkg::mode_t       mode, mode_next;
  scfr_pkg::frame_type_t type_code, type_code_next;
  logic [7:0]  bytes_received, bytes_received_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] idle_count, idle_count_next;
  logic [15:0] timeout_ticks;

  logic        accept;
  logic [7:0]  items;
  logic [7:0]  items_p1;
  logic [7:0]  items_p3;
  logic [7:0]  count;
  logic [15:0] idle_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (type_code)
      scfr_pkg::TYPE_LONG:  items = 8'(LONG_ITEMS);
      scfr_pkg::TYPE_SHORT: items = 8'(SHORT_ITEMS);
      default:              items = 8'd0;
    endcase
  end

  assign items_p1 = items + 8'd1;
  assign items_p3 = items + 8'd3;
  assign count    = (bytes_received == 8'hFF) ? 8'hFF : bytes_received + 8'd1;
  assign idle_inc = (idle_count == 16'hFFFF) ? 16'hFFFF : idle_count + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= scfr_pkg::MODE_CLOSED;
      type_code      <= scfr_pkg::TYPE_NONE;
      bytes_received <= 8'd0;
      running_sum    <= 8'd0;
      idle_count     <= 16'd0;
      timeout_ticks  <= scfr_pkg::TIMEOUT_RESET;
    end else begin
      mode           <= mode_next;
      type_code      <= type_code_next;
      bytes_received <= bytes_received_next;
      running_sum    <= running_sum_next;
      idle_count     <= idle_count_next;
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
    end
  end

  always_comb begin
    logic clear;
    clear               = 1'b0;
    mode_next           = mode;
    type_code_next      = type_code;
    bytes_received_next = bytes_received;
    running_sum_next    = running_sum;
    idle_count_next     = idle_count;
    push                = 1'b0;
    push_cmd            = '0;
    if (accept) begin
      unique case (in_func)
        scfr_pkg::FUNC_OPEN: begin
          if (mode == scfr_pkg::MODE_CLOSED) begin
            mode_next = scfr_pkg::MODE_READY;
            clear     = 1'b1;
          end
        end
        scfr_pkg::FUNC_CLOSE: begin
          mode_next = scfr_pkg::MODE_CLOSED;
          clear     = 1'b1;
        end
        scfr_pkg::FUNC_READ: begin
          push = 1'b1;
          if (mode != scfr_pkg::MODE_READY) begin
            push_cmd.kind = scfr_pkg::KIND_REFUSED;
          end else begin
            push_cmd.kind = scfr_pkg::KIND_TX;
            mode_next     = scfr_pkg::MODE_READING;
            clear         = 1'b1;
          end
        end
        scfr_pkg::FUNC_BYTE: begin
          if (mode == scfr_pkg::MODE_READING) begin
            idle_count_next     = 16'd0;
            bytes_received_next = count;
            if (bytes_received == 8'd0) begin
              if (in_rx == scfr_pkg::TYPE_BYTE_LONG) begin
                type_code_next = scfr_pkg::TYPE_LONG;
              end else if (in_rx == scfr_pkg::TYPE_BYTE_SHORT) begin
                type_code_next = scfr_pkg::TYPE_SHORT;
              end else begin
                type_code_next = scfr_pkg::TYPE_NONE;
              end
            end else if (items != 8'd0) begin
              // Count byte and items are summed; later bytes are checksum candidates.
              if (bytes_received <= items_p1) begin
                running_sum_next = running_sum + in_rx;
              end else if (count >= items_p3 && in_rx == running_sum) begin
                push                = 1'b1;
                push_cmd.kind       = scfr_pkg::KIND_FRAME;
                push_cmd.frame_type = (type_code == scfr_pkg::TYPE_SHORT);
                push_cmd.exact      = (count == items_p3);
                mode_next           = scfr_pkg::MODE_READY;
                clear               = 1'b1;
              end
            end
          end
        end
        scfr_pkg::FUNC_TICK: begin
          if (mode == scfr_pkg::MODE_READING) begin
            idle_count_next = idle_inc;
            if (idle_inc >= timeout_ticks) begin
              push          = 1'b1;
              push_cmd.kind = scfr_pkg::KIND_TIMEOUT;
              mode_next     = scfr_pkg::MODE_READY;
              clear         = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (clear) begin
      type_code_next      = scfr_pkg::TYPE_NONE;
      bytes_received_next = 8'd0;
      running_sum_next    = 8'd0;
      idle_count_next     = 16'd0;
    end
  end

endmodule

`default_nettype wire

/* hdl/scfr_queue.sv */
// Short command queue between the front and back ends.
// Depends on scfr_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module scfr_queue #(
  parameter int DEPTH = 4
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  scfr_pkg::cmd_t  push_cmd,
  input  wire             pop,
  output logic            full,
  output logic            empty,
  output scfr_pkg::cmd_t  head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scfr_pkg::cmd_t store [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign head  = store[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* hdl/scfr_back.sv */
// Back end: expands queued commands into result beats into an output register.
// Depends on scfr_pkg for the command type and the request byte table.
`timescale 1ns / 1ps
`default_nettype none

module scfr_back (
  input  wire             clk,
  input  wire             rst,
  input  wire             q_empty,
  input  scfr_pkg::cmd_t  head,
  output logic            pop,
  output logic            out_valid,
  input  wire             out_ready,
  output logic [15:0]     out_data,
  output logic [1:0]      out_user,
  output logic            out_last
);

  logic [2:0] beat;
  logic       load;
  logic       last_beat;

  assign load      = !q_empty && (!out_valid || out_ready);
  assign last_beat = (head.kind != scfr_pkg::KIND_TX) || (beat == scfr_pkg::REQ_LAST);
  assign pop       = load && last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat      <= last_beat ? 3'd0 : beat + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_user <= 2'(head.kind);
      out_last <= last_beat;
      if (head.kind == scfr_pkg::KIND_TX) begin
        out_data <= {8'd0, scfr_pkg::request_byte(beat)};
      end else begin
        out_data <= {6'd0, head.exact, head.frame_type, 8'd0};
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/sum_checked_frame_read_transaction_unit.sv */
// Top level of the sum-checked frame read transaction unit.
// Depends on scfr_pkg, scfr_front, scfr_queue and scfr_back.
//
//   channel   direction  payload
//   s_axis    in         tuser: func; tdata: rx_byte
//   m_axis    out        tuser: kind; tdata: tx_byte, frame_type, exact_length; tlast
//   cfg       in         timeout_ticks write, taken whenever cfg_we is high
//
// The front end takes one request per cycle while the command queue has room and
// updates the frame state in that same cycle. A read request accepted in ready mode
// yields five result beats, every other producing request one; the output register
// issues one beat per cycle while m_axis_tready holds, and results pass through
// the command queue and then the output register. Reset (rst, synchronous)
// closes the unit, empties the queue and sets the timeout to 100 ticks.
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_read_transaction_unit #(
  parameter int LONG_ITEMS  = 24,
  parameter int SHORT_ITEMS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire  [2:0]  s_axis_tuser,   // [2:0] func
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [8] frame_type, [9] exact_length
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  logic           push, pop, q_full, q_empty;
  scfr_pkg::cmd_t push_cmd, head;

  scfr_front #(
    .LONG_ITEMS (LONG_ITEMS),
    .SHORT_ITEMS(SHORT_ITEMS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_rx    (s_axis_tdata),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  scfr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head)
  );

  scfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

endmodule

`default_nettype wire
